FILE: design/b64e_pkg.sv
// Shared types, constants and the sextet-to-character mapping for the base64 encoder.
package b64e_pkg;

    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned MAX_CHARS = 4;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

    // One encoded byte: up to four characters, the index of the final one and
    // whether this byte closes the message.
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [1:0]                       last_idx;
        logic                             last;
    } cmd_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
        logic [CHAR_W-1:0] c;
        if (v < 6'd26)
        begin
            c = {1'b0, v} + 7'h41;
        end
        else if (v < 6'd52)
        begin
            c = {1'b0, v} + 7'd71;
        end
        else if (v < 6'd62)
        begin
            c = {1'b0, v} - 7'd4;
        end
        else if (v == 6'd62)
        begin
            c = 7'h2B;
        end
        else
        begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage

FILE: design/b64e_if.sv
// Valid/ready channel interfaces for the byte input and character output.
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

FILE: design/b64e_front.sv
// Front end: accepts bytes, tracks group position and leftover bits, builds character words.
module b64e_front
    import b64e_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic [7:0] data_byte,
    input  logic last_byte,
    input  logic q_full,
    output logic in_ready,
    output logic push,
    output cmd_t push_cmd
);

    typedef enum logic [2:0] {
        PH0 = 3'b001,
        PH1 = 3'b010,
        PH2 = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] left_reg, left_next;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        push_cmd.chars    = '{default: PAD_CHAR};
        push_cmd.last     = last_byte;
        push_cmd.last_idx = 2'd0;
        unique case (phase_reg)
            PH1:
            begin
                push_cmd.chars[0] = sextet_char({left_reg[1:0], data_byte[7:4]});
                if (last_byte)
                begin
                    push_cmd.chars[1] = sextet_char({data_byte[3:0], 2'b00});
                    push_cmd.last_idx = 2'd2;
                end
                else
                begin
                    left_next  = data_byte[3:0];
                    phase_next = PH2;
                end
            end
            PH2:
            begin
                push_cmd.chars[0] = sextet_char({left_reg, data_byte[7:6]});
                push_cmd.chars[1] = sextet_char(data_byte[5:0]);
                push_cmd.last_idx = 2'd1;
                left_next  = 4'd0;
                phase_next = PH0;
            end
            default:
            begin
                push_cmd.chars[0] = sextet_char(data_byte[7:2]);
                if (last_byte)
                begin
                    push_cmd.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
                    push_cmd.last_idx = 2'd3;
                end
                else
                begin
                    left_next  = {2'b00, data_byte[1:0]};
                    phase_next = PH1;
                end
            end
        endcase
        if (last_byte)
        begin
            left_next  = 4'd0;
            phase_next = PH0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH0;
            left_reg  <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

FILE: design/b64e_queue.sv
// Small FIFO of character words between the front and back ends.
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: design/b64e_back.sv
// Back end: walks each character word and drives one character per cycle into the output register unless it stalls.
module b64e_back
    import b64e_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  cmd_t q_cmd,
    output logic pop,
    input  logic char_ready,
    output logic char_valid,
    output logic [CHAR_W-1:0] out_char,
    output logic last_char
);

    cmd_t              cmd_reg;
    logic              busy_reg;
    logic [1:0]        idx_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg;
    logic              advance, done;

    assign advance = busy_reg && (!out_valid_reg || char_ready);
    assign done    = advance && (idx_reg == cmd_reg.last_idx);
    assign pop     = q_valid && (!busy_reg || done);

    assign char_valid = out_valid_reg;
    assign out_char   = out_char_reg;
    assign last_char  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (advance)
        begin
            out_char_reg <= cmd_reg.chars[idx_reg];
            out_last_reg <= cmd_reg.last && (idx_reg == cmd_reg.last_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (char_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: design/base64_stream_encoder_unit.sv
// Base64 stream encoder top level: front end, word queue and character back end.
//
// Usage: bytes enter on byte_stream (valid/ready), one per word, with last_byte
// set on the final byte of a message. Characters leave on char_stream, one per
// word, drawn from the standard alphabet with '=' padding; last_char marks the
// final character of the message.
// Path: the first character of a byte moves from the queue into the back end's
// word register and from there into the output register.
// Throughput: the output register moves one character per cycle unless
// char_stream.ready stalls it, and three bytes expand to four characters; a
// single byte may be accepted every cycle while the queue (QUEUE_DEPTH words)
// has room. A closing byte expands to up to four characters.
// Reset: clears the group position, the leftover bits, the queue and the
// output valid flag; encoding resumes at the start of a group.
// Stall: when char_stream.ready is low the output register holds its character,
// the back end holds its word, and the queue fills; byte_stream.ready drops
// only once the queue is full.
module base64_stream_encoder_unit
    import b64e_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    b64e_byte_if.sink   byte_stream,
    b64e_char_if.source char_stream
);

    cmd_t push_cmd, pop_cmd;
    logic push, pop, q_full, q_valid;

    // Classify each byte by group position and build its character word.
    b64e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_stream.valid),
        .data_byte (byte_stream.data_byte),
        .last_byte (byte_stream.last_byte),
        .q_full    (q_full),
        .in_ready  (byte_stream.ready),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Decouple byte acceptance from character delivery.
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_cmd   (pop_cmd)
    );

    // Serialize each word into characters.
    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (pop_cmd),
        .pop        (pop),
        .char_ready (char_stream.ready),
        .char_valid (char_stream.valid),
        .out_char   (char_stream.out_char),
        .last_char  (char_stream.last_char)
    );

endmodule

FILE: design/b64e_checker.sv
// Port-level checks on the encoder's character output, bound to the top level.
module b64e_checker
    import b64e_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              char_valid,
    input logic              char_ready,
    input logic [CHAR_W-1:0] out_char,
    input logic              last_char
);

    logic char_take;
    logic legal;

    assign char_take = char_valid && char_ready;
    assign legal = (out_char >= 7'h41 && out_char <= 7'h5A) ||
                   (out_char >= 7'h61 && out_char <= 7'h7A) ||
                   (out_char >= 7'h30 && out_char <= 7'h39) ||
                   (out_char == 7'h2B) || (out_char == 7'h2F) ||
                   (out_char == PAD_CHAR);

    // Hold a stalled character and its mark.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid && $stable(out_char) && $stable(last_char))
        else $error("stalled character changed");

    // Emit only alphabet characters or padding.
    a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> legal)
        else $error("character outside the base64 alphabet");

    // A non-final pad is followed at once by the final pad.
    a_pad_pair: assert property (@(posedge clk) disable iff (!rst_n)
        char_take && out_char == PAD_CHAR && !last_char |=>
            char_valid && out_char == PAD_CHAR && last_char)
        else $error("first pad not followed by closing pad");

    // A message that closed on a pad is not followed at once by a non-final pad.
    a_pad_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_take && last_char |=> !(char_valid && out_char == PAD_CHAR && !last_char &&
            $past(out_char) == PAD_CHAR))
        else $error("pad follows a closed message");

endmodule

bind base64_stream_encoder_unit b64e_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_stream.valid),
    .char_ready (char_stream.ready),
    .out_char   (char_stream.out_char),
    .last_char  (char_stream.last_char)
);
